### hw/rtl/fp3d_pkg.sv
// ----------------------------------------------------------------------------
// fp3d_pkg
// Shared widths and types for the fixed-point 3D distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fp3d_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned MagW     = CoordW - FracBits;   // integer part magnitude
  localparam int unsigned SumW     = 32;                  // exact: at most 3 * 2^30
  localparam int unsigned RootW    = 16;
  localparam int unsigned RemW     = RootW + 2;           // partial remainder < 2*root + 1
  localparam int unsigned NumRootStages = RootW;          // one result bit per stage
  localparam logic [RootW-1:0] MaxDist = RootW'(56755);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [SumW-1:0]          sum_t;

  // Carried between square root digit stages
  typedef struct packed {
    logic [SumW-1:0]  rad;   // radicand, next digit pair in the top two bits
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } root_t;

endpackage

`default_nettype wire

### hw/rtl/fp3d_front.sv
// ----------------------------------------------------------------------------
// fp3d_front
// Three pipeline stages: axis delta magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module fp3d_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  output logic                   stall_o,
  input  wire fp3d_pkg::coord_t  first_x_i,
  input  wire fp3d_pkg::coord_t  first_y_i,
  input  wire fp3d_pkg::coord_t  first_z_i,
  input  wire fp3d_pkg::coord_t  second_x_i,
  input  wire fp3d_pkg::coord_t  second_y_i,
  input  wire fp3d_pkg::coord_t  second_z_i,
  output logic                   valid_o,
  input  wire                    stall_i,
  output fp3d_pkg::sum_t         sum_o
);

  logic            mag_valid_q, sq_valid_q, sum_valid_q;
  logic            mag_adv, sq_adv, sum_adv;
  fp3d_pkg::mag_t  mag_d [3];
  fp3d_pkg::mag_t  mag_q [3];
  fp3d_pkg::sum_t  sq_q  [3];
  fp3d_pkg::sum_t  sum_q;
  fp3d_pkg::coord_t diff [3];

  // a stage moves when empty or when its successor takes the request
  assign sum_adv = !sum_valid_q || !stall_i;
  assign sq_adv  = !sq_valid_q  || sum_adv;
  assign mag_adv = !mag_valid_q || sq_adv;

  assign stall_o = !mag_adv;
  assign valid_o = sum_valid_q;
  assign sum_o   = sum_q;

  assign diff[0] = first_x_i - second_x_i;
  assign diff[1] = first_y_i - second_y_i;
  assign diff[2] = first_z_i - second_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // two's complement negate of the integer part; -32768 maps to 0x8000
      if (diff[a][fp3d_pkg::CoordW-1]) begin
        mag_d[a] = fp3d_pkg::mag_t'(0) - diff[a][fp3d_pkg::CoordW-1:fp3d_pkg::FracBits];
      end else begin
        mag_d[a] = diff[a][fp3d_pkg::CoordW-1:fp3d_pkg::FracBits];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (mag_adv) mag_valid_q <= valid_i;
      if (sq_adv)  sq_valid_q  <= mag_valid_q;
      if (sum_adv) sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_adv && valid_i) begin
      for (int a = 0; a < 3; a++) mag_q[a] <= mag_d[a];
    end
    if (sq_adv && mag_valid_q) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= fp3d_pkg::sum_t'(mag_q[a]) * fp3d_pkg::sum_t'(mag_q[a]);
      end
    end
    if (sum_adv && sq_valid_q) begin
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fp3d_root_step.sv
// ----------------------------------------------------------------------------
// fp3d_root_step
// One registered digit step of the restoring integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module fp3d_root_step (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  stall_o,
  input  wire fp3d_pkg::root_t  data_i,
  output logic                  valid_o,
  input  wire                   stall_i,
  output fp3d_pkg::root_t       data_o
);

  localparam int unsigned TrialW = fp3d_pkg::RemW + 2;

  logic                  valid_q, adv;
  fp3d_pkg::root_t       data_q, data_d;
  logic [TrialW-1:0]     rem_sh, trial, diff;
  logic                  take;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  assign rem_sh = {data_i.rem, data_i.rad[fp3d_pkg::SumW-1 -: 2]};
  assign trial  = TrialW'({data_i.root, 2'b01});
  assign diff   = rem_sh - trial;
  assign take   = (rem_sh >= trial);

  always_comb begin
    data_d.rad  = {data_i.rad[fp3d_pkg::SumW-3:0], 2'b00};
    data_d.rem  = take ? diff[fp3d_pkg::RemW-1:0] : rem_sh[fp3d_pkg::RemW-1:0];
    data_d.root = {data_i.root[fp3d_pkg::RootW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fixed_point_3d_distance.sv
// Pipeline: 3 front stages and 16 root digit stages.
// Throughput: one request per cycle while the output is not stalled; each stage holds one request and moves when
// its successor frees, so empty slots close up under output stall.
// Reset: asynchronous, active low; clears all stage valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// fixed_point_3d_distance
// Floor Euclidean distance between two 16.16 positions, integer parts only.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_3d_distance (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [fp3d_pkg::CoordW-1:0] first_x_i,
  input  wire  [fp3d_pkg::CoordW-1:0] first_y_i,
  input  wire  [fp3d_pkg::CoordW-1:0] first_z_i,
  input  wire  [fp3d_pkg::CoordW-1:0] second_x_i,
  input  wire  [fp3d_pkg::CoordW-1:0] second_y_i,
  input  wire  [fp3d_pkg::CoordW-1:0] second_z_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [fp3d_pkg::RootW-1:0]  distance_o
);

  localparam int unsigned N = fp3d_pkg::NumRootStages;

  logic            front_valid, front_stall;
  fp3d_pkg::sum_t  front_sum;

  logic            st_valid [N+1];
  logic            st_stall [N+1];
  fp3d_pkg::root_t st_data  [N+1];

  fp3d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (in_stall_o),
    .first_x_i  (fp3d_pkg::coord_t'(first_x_i)),
    .first_y_i  (fp3d_pkg::coord_t'(first_y_i)),
    .first_z_i  (fp3d_pkg::coord_t'(first_z_i)),
    .second_x_i (fp3d_pkg::coord_t'(second_x_i)),
    .second_y_i (fp3d_pkg::coord_t'(second_y_i)),
    .second_z_i (fp3d_pkg::coord_t'(second_z_i)),
    .valid_o    (front_valid),
    .stall_i    (front_stall),
    .sum_o      (front_sum)
  );

  assign st_valid[0]     = front_valid;
  assign front_stall     = st_stall[0];
  assign st_data[0].rad  = front_sum;
  assign st_data[0].rem  = '0;
  assign st_data[0].root = '0;

  for (genvar g = 0; g < N; g++) begin : g_root
    fp3d_root_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .stall_o (st_stall[g]),
      .data_i  (st_data[g]),
      .valid_o (st_valid[g+1]),
      .stall_i (st_stall[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  assign st_stall[N]  = out_stall_i;
  assign out_valid_o  = st_valid[N];
  assign distance_o   = st_data[N].root;

`ifndef SYNTHESIS
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o <= fp3d_pkg::MaxDist)
    else $error("distance above largest reachable value");

  a_no_stall_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output stage");
`endif

endmodule

`default_nettype wire

### tb/tb_fixed_point_3d_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_3d_distance
// Self-checking bench for the 16.16 fixed-point 3D distance pipeline.
// Position pairs are streamed through the request channel with random gaps.
// The result side is stalled at random. Every distance is compared in order
// with a behavioural prediction: wrapped axis deltas, integer parts squared,
// and the floor square root of the summed squares.
// ----------------------------------------------------------------------------

module tb_fixed_point_3d_distance;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_PAIRS = 500;
  localparam int SETTLE_CYCLES = 40;        // comfortably past the pipeline latency
  localparam int CYCLE_LIMIT  = 400000;

  localparam fp3d_pkg::coord_t CORNER_VALS [8] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_0000
  };

  typedef struct {
    fp3d_pkg::coord_t fx, fy, fz;
    fp3d_pkg::coord_t sx, sy, sz;
    bit     hold;       // wait for the pipeline to drain before sending
  } pos_pair_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [fp3d_pkg::CoordW-1:0]   first_x_i = '0;
  logic [fp3d_pkg::CoordW-1:0]   first_y_i = '0;
  logic [fp3d_pkg::CoordW-1:0]   first_z_i = '0;
  logic [fp3d_pkg::CoordW-1:0]   second_x_i = '0;
  logic [fp3d_pkg::CoordW-1:0]   second_y_i = '0;
  logic [fp3d_pkg::CoordW-1:0]   second_z_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [fp3d_pkg::RootW-1:0]    distance_o;

  pos_pair_t                     pair_backlog[$];
  logic [fp3d_pkg::RootW-1:0]    dist_expected[$];
  pos_pair_t                     pair_on_bus;
  pos_pair_t                     pair_next;
  int                            send_gap;
  int                            send_calm;
  int                            stall_left;
  int                            stall_calm;
  int                            error_count;
  int                            sent_count;
  int                            checked_count;
  int                            max_dist_seen;
  int unsigned                   cycle_count;

  fixed_point_3d_distance uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .first_z_i   (first_z_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .second_z_i  (second_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Squared integer part of one wrapped axis delta
  function automatic int unsigned axis_sq(fp3d_pkg::coord_t a, fp3d_pkg::coord_t b);
    fp3d_pkg::coord_t delta;
    int     whole;
    delta = a - b;
    whole = int'($signed(delta[fp3d_pkg::CoordW-1:fp3d_pkg::FracBits]));
    if (whole < 0) whole = -whole;
    return int'(whole * whole);
  endfunction

  function automatic logic [fp3d_pkg::RootW-1:0] predict_distance(pos_pair_t p);
    int unsigned                sum;
    logic [fp3d_pkg::RootW-1:0] root;
    logic [fp3d_pkg::RootW-1:0] trial;
    sum = axis_sq(p.fx, p.sx) + axis_sq(p.fy, p.sy) + axis_sq(p.fz, p.sz);
    root = '0;
    // set root bits from the top while the square stays within the sum
    for (int i = fp3d_pkg::RootW - 1; i >= 0; i--) begin
      trial = root;
      trial[i] = 1'b1;
      if (longint'(trial) * longint'(trial) <= longint'(sum)) root = trial;
    end
    return root;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic fp3d_pkg::coord_t near_coord(fp3d_pkg::coord_t base);
    fp3d_pkg::coord_t offset;
    offset = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 1) != 0) offset = -offset;
    return base + offset;
  endfunction

  function automatic fp3d_pkg::coord_t corner_coord();
    return CORNER_VALS[$urandom_range(0, 7)];
  endfunction

  task automatic add_pair(fp3d_pkg::coord_t fx, fp3d_pkg::coord_t fy, fp3d_pkg::coord_t fz,
                          fp3d_pkg::coord_t sx, fp3d_pkg::coord_t sy, fp3d_pkg::coord_t sz,
                          bit hold = 1'b0);
    pos_pair_t p;
    p.fx = fx; p.fy = fy; p.fz = fz;
    p.sx = sx; p.sy = sy; p.sz = sz;
    p.hold = hold;
    pair_backlog.push_back(p);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        dist_expected.push_back(predict_distance(pair_on_bus));
        sent_count++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pair_backlog.size() == 0 ||
                   (pair_backlog[0].hold && dist_expected.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        pair_next = pair_backlog.pop_front();
        pair_on_bus = pair_next;
        in_valid_i <= 1'b1;
        first_x_i <= pair_next.fx;
        first_y_i <= pair_next.fy;
        first_z_i <= pair_next.fz;
        second_x_i <= pair_next.sx;
        second_y_i <= pair_next.sy;
        second_z_i <= pair_next.sz;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(20, 60);
          send_gap = gap_len();
        end
      end
    end
  end

  // Result monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      stall_calm = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (dist_expected.size() == 0) begin
          $error("distance: no request pending, got %0d", distance_o);
          error_count++;
        end else begin
          if (distance_o !== dist_expected[0]) begin
            $error("distance: expected %0d, actual %0d", dist_expected[0], distance_o);
            error_count++;
          end
          if (int'(dist_expected[0]) > max_dist_seen) max_dist_seen = int'(dist_expected[0]);
          void'(dist_expected.pop_front());
          checked_count++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (stall_calm > 0) begin
        stall_calm--;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) stall_calm = $urandom_range(20, 80);
        stall_left = gap_len();
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    fp3d_pkg::coord_t base;
    int     kind;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    max_dist_seen = 0;
    cycle_count = 0;

    // Directed: zeros, equal positions, wrapped deltas, fractions, extremes
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(32'h7FFF_0000, 0, 0, 32'h8000_0000, 0, 0);        // wraps to -1
    add_pair(0, 32'h8000_0000, 0, 0, 32'h7FFF_0000, 0);        // wraps to +1
    add_pair(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);  // largest sum
    add_pair(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    add_pair(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0, 0);  // fraction only
    add_pair(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);  // -1 each axis
    add_pair(32'h0001_0000, 0, 0, 0, 0, 0);
    add_pair(32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 0, 0);
    add_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    add_pair(32'h0002_0000, 32'h0003_0000, 32'h0006_0000, 0, 0, 0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
             32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    add_pair(32'h0100_0000, 32'hFF00_0000, 32'h00FF_8000,
             32'hFF00_0000, 32'h0100_0000, 32'hFF00_8000);

    // Random pairs; two of them wait for the pipeline to empty first
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      kind = $urandom_range(0, 99);
      base = $urandom();
      if (kind < 40) begin
        add_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 n == 0 || n == RANDOM_PAIRS / 2);
      end else if (kind < 70) begin
        add_pair(base, base ^ 32'h5A5A_0F0F, ~base,
                 near_coord(base), near_coord(base ^ 32'h5A5A_0F0F), near_coord(~base),
                 n == 0 || n == RANDOM_PAIRS / 2);
      end else if (kind < 90) begin
        add_pair(corner_coord(), corner_coord(), corner_coord(),
                 corner_coord(), corner_coord(), corner_coord(),
                 n == 0 || n == RANDOM_PAIRS / 2);
      end else begin
        add_pair(base, ~base, base + 32'h0001_0000, base, ~base, base + 32'h0001_0000,
                 n == 0 || n == RANDOM_PAIRS / 2);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_backlog.size() != 0 || in_valid_i || dist_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (dist_expected.size() != 0) begin
      $error("distance: %0d requests never answered", dist_expected.size());
      error_count++;
    end

    $display("Sent %0d position pairs, checked %0d distances (largest %0d).",
             sent_count, checked_count, max_dist_seen);
    $display("Covered wrapped deltas, corner coordinates, equal positions and random stalls.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/fp3d_pkg.sv
hw/rtl/fp3d_front.sv
hw/rtl/fp3d_root_step.sv
hw/rtl/fixed_point_3d_distance.sv
tb/tb_fixed_point_3d_distance.sv
